// File: hw/rtl/gthn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gthn_pkg: shared constants and types
// Sizes, item codes and result status codes of the two-hop neighborhood block.
// ----------------------------------------------------------------------------
package gthn_pkg;
  localparam int MAX_NODES  = 64;
  localparam int MAX_DEGREE = 16;
  localparam int SLOT_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int DIDX_W     = $clog2(MAX_DEGREE);
  localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
  localparam int ADJ_AW     = SLOT_W + DIDX_W;
  localparam int ID_W       = 16;

  localparam logic [1:0] MODE_ADD_NODE = 2'd0;
  localparam logic [1:0] MODE_ADD_EDGE = 2'd1;
  localparam logic [1:0] MODE_QUERY    = 2'd2;
  localparam logic [1:0] MODE_RSVD     = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]      status;
    logic            has_member;
    logic [ID_W-1:0] member_id;
    logic [1:0]      hop;
    logic            last;
  } result_t;
endpackage
`default_nettype wire

// File: hw/rtl/graph_two_hop_neighbourhood_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_two_hop_neighbourhood_top: graph store with two-hop query
// Node table, adjacency memory and a sequencer that walks them entry by entry
// to answer add-node, add-edge and two-hop query items.
// ----------------------------------------------------------------------------
//   channel  handshake             payload
//   in       in_valid / in_ready   in_mode, in_id_a, in_id_b
//   out      out_valid / out_ready out_status, out_has_member, out_member_id,
//                                  out_hop, out_last
// Steps: add node does a linear id search. Add edge does two id searches and
// a scan of a's list for b. A query does one search, clears the seen map
// over all MAX_NODES entries, then walks the list of a and the list of each
// direct neighbor, emitting each new member.
// Reset clears node_count and the control state; memories are not cleared.
// in_ready is low while an item is in work; a stalled result holds the walk.
module graph_two_hop_neighbourhood_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_id_a,
  input  wire logic [15:0] in_id_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_has_member,
  output logic [15:0]      out_member_id,
  output logic [1:0]       out_hop,
  output logic             out_last
);
  localparam int SW = gthn_pkg::SLOT_W;
  localparam int CW = gthn_pkg::CNT_W;
  localparam int DW = gthn_pkg::DEG_W;
  localparam int IW = gthn_pkg::ID_W;
  localparam int AW = gthn_pkg::ADJ_AW;
  localparam int XW = gthn_pkg::DIDX_W;

  typedef enum logic [14:0] {
    S_IDLE  = 15'd1,    S_FIND  = 15'd2,    S_DISP  = 15'd4,
    S_LINK  = 15'd8,    S_LINKC = 15'd16,   S_WRA   = 15'd32,
    S_WRB   = 15'd64,   S_CLR   = 15'd128,  S_ADJ   = 15'd256,
    S_CHK   = 15'd512,  S_EMIT  = 15'd1024, S_NEXTF = 15'd2048,
    S_FLUSH = 15'd4096, S_RES   = 15'd8192, S_LDEG  = 15'd16384
  } state_t;

  state_t state_r, state_nxt;

  // memories and tables
  logic [IW-1:0] node_mem [gthn_pkg::MAX_NODES];
  logic [SW-1:0] adj_mem  [gthn_pkg::MAX_NODES * gthn_pkg::MAX_DEGREE];
  logic [DW-1:0] deg_mem  [gthn_pkg::MAX_NODES];
  logic [SW-1:0] fl_mem   [gthn_pkg::MAX_NODES];
  logic [gthn_pkg::MAX_NODES-1:0] seen_r;

  logic [CW-1:0] node_count_r;
  logic [1:0]    mode_r;
  logic [IW-1:0] ida_r, idb_r;
  logic          which_r;                 // 0 searching id_a, 1 id_b
  logic [CW-1:0] idx_r;                   // search / clear index
  logic [SW-1:0] sa_r, sb_r, cur_r;       // slots of a, b, current node
  logic [DW-1:0] d_r;                     // remaining entries of current list
  logic [DW-1:0] dega_r, degb_r;
  logic          level2_r;
  logic [CW-1:0] n1_r, fi_r;
  logic          any_r;
  logic          pend_r;                  // one held member waiting
  logic [IW-1:0] pend_id_r;               // id of the held member
  logic [SW-1:0] mem_slot_r;              // slot of the member being looked up
  logic          pend_hop2_r;

  // registered read ports
  logic [IW-1:0] node_rd_r;
  logic [SW-1:0] adj_rd_r;
  logic [DW-1:0] deg_rd_r;
  logic [SW-1:0] fl_rd_r;

  logic [SW-1:0] node_ra, fl_ra;
  logic [AW-1:0] adj_ra;
  logic [SW-1:0] deg_ra;

  logic              push;
  gthn_pkg::result_t push_data, out_data;
  logic              oq_full;

  // sequencer
  logic [1:0] res_status_r;
  logic [1:0] res_status_nxt;

  logic          node_we, adj_we, deg_we, fl_we;
  logic [SW-1:0] node_wa, deg_wa, fl_wa;
  logic [AW-1:0] adj_wa;
  logic [SW-1:0] adj_wd, fl_wd;
  logic [DW-1:0] deg_wd;

  logic [CW-1:0] idx_nxt, n1_nxt, fi_nxt;
  logic [SW-1:0] sa_nxt, sb_nxt, cur_nxt, mem_slot_nxt;
  logic [DW-1:0] d_nxt, dega_nxt, degb_nxt;
  logic          which_nxt, level2_nxt, any_nxt, pend_nxt, pend_hop2_nxt;
  logic [gthn_pkg::MAX_NODES-1:0] seen_nxt;
  logic [1:0]    mode_nxt;
  logic [IW-1:0] ida_nxt, idb_nxt, pend_id_nxt;
  logic [CW-1:0] cnt_nxt;
  logic [IW-1:0] key;
  logic [SW-1:0] nb;

  assign key = which_r ? idb_r : ida_r;
  assign nb  = adj_rd_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r; n1_nxt = n1_r; fi_nxt = fi_r;
    sa_nxt = sa_r; sb_nxt = sb_r; cur_nxt = cur_r; d_nxt = d_r;
    dega_nxt = dega_r; degb_nxt = degb_r;
    which_nxt = which_r; level2_nxt = level2_r; any_nxt = any_r;
    pend_nxt = pend_r; mem_slot_nxt = mem_slot_r; pend_hop2_nxt = pend_hop2_r;
    pend_id_nxt = pend_id_r;
    seen_nxt = seen_r; mode_nxt = mode_r; ida_nxt = ida_r; idb_nxt = idb_r;
    cnt_nxt = node_count_r; res_status_nxt = res_status_r;
    node_we = 1'b0; adj_we = 1'b0; deg_we = 1'b0; fl_we = 1'b0;
    node_wa = node_count_r[SW-1:0];
    deg_wa = sa_r; deg_wd = '0;
    adj_wa = {sa_r, dega_r[XW-1:0]}; adj_wd = sb_r;
    fl_wa = n1_r[SW-1:0]; fl_wd = nb;
    node_ra = idx_r[SW-1:0];
    adj_ra = {cur_r, XW'(d_r - DW'(1))};
    deg_ra = cur_r;
    fl_ra = fi_r[SW-1:0];
    push = 1'b0;
    push_data = '0;
    push_data.last = 1'b1;
    in_ready = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode; ida_nxt = in_id_a; idb_nxt = in_id_b;
          idx_nxt = '0; which_nxt = 1'b0; node_ra = '0;
          if (in_mode inside {gthn_pkg::MODE_ADD_NODE, gthn_pkg::MODE_ADD_EDGE,
                              gthn_pkg::MODE_QUERY}) begin
            state_nxt = S_FIND;
          end else begin
            res_status_nxt = gthn_pkg::ST_DONE;
            state_nxt = S_RES;
          end
        end
      end
      // node_rd_r holds entry idx_r; next read at idx_r+1
      S_FIND: begin
        node_ra = SW'(idx_r + CW'(1));
        deg_ra = idx_r[SW-1:0];
        if (idx_r >= node_count_r) begin
          state_nxt = S_DISP;
          if (which_r) sb_nxt = '1; else sa_nxt = '1;
          any_nxt = 1'b0;   // not found marker
        end else if (node_rd_r == key) begin
          if (which_r) sb_nxt = idx_r[SW-1:0]; else sa_nxt = idx_r[SW-1:0];
          any_nxt = 1'b1;
          state_nxt = S_DISP;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      // deg_rd_r holds the degree of the found slot
      S_DISP: begin
        if (which_r) degb_nxt = deg_rd_r; else dega_nxt = deg_rd_r;
        case (mode_r)
          gthn_pkg::MODE_ADD_NODE: begin
            if (any_r) res_status_nxt = gthn_pkg::ST_DUP;
            else if (node_count_r >= CW'(gthn_pkg::MAX_NODES))
              res_status_nxt = gthn_pkg::ST_FULL;
            else begin
              res_status_nxt = gthn_pkg::ST_DONE;
              node_we = 1'b1;
              deg_we = 1'b1; deg_wa = node_count_r[SW-1:0]; deg_wd = '0;
              cnt_nxt = node_count_r + CW'(1);
            end
            state_nxt = S_RES;
          end
          gthn_pkg::MODE_ADD_EDGE: begin
            if (!any_r) begin
              res_status_nxt = gthn_pkg::ST_MISS;
              state_nxt = S_RES;
            end else if (!which_r) begin
              which_nxt = 1'b1; idx_nxt = '0; node_ra = '0;
              state_nxt = S_FIND;
            end else begin
              cur_nxt = sa_r; d_nxt = dega_r;
              state_nxt = S_LINK;
            end
          end
          default: begin
            if (!any_r) begin
              res_status_nxt = gthn_pkg::ST_MISS;
              state_nxt = S_RES;
            end else begin
              idx_nxt = '0;
              state_nxt = S_CLR;
            end
          end
        endcase
      end
      // scan a's list for b, issuing reads from the top down
      S_LINK: begin
        if (d_r == '0) begin
          if (dega_r >= DW'(gthn_pkg::MAX_DEGREE) || degb_r >= DW'(gthn_pkg::MAX_DEGREE)) begin
            res_status_nxt = gthn_pkg::ST_FULL;
            state_nxt = S_RES;
          end else state_nxt = S_WRA;
        end else state_nxt = S_LINKC;
      end
      S_LINKC: begin
        if (nb == sb_r) begin
          res_status_nxt = gthn_pkg::ST_DUP;
          state_nxt = S_RES;
        end else begin
          d_nxt = d_r - DW'(1);
          state_nxt = S_LINK;
        end
      end
      S_WRA: begin
        adj_we = 1'b1;
        deg_we = 1'b1; deg_wa = sa_r; deg_wd = dega_r + DW'(1);
        if (sa_r == sb_r) begin
          res_status_nxt = gthn_pkg::ST_DONE;
          state_nxt = S_RES;
        end else state_nxt = S_WRB;
      end
      S_WRB: begin
        adj_we = 1'b1; adj_wa = {sb_r, degb_r[XW-1:0]}; adj_wd = sa_r;
        deg_we = 1'b1; deg_wa = sb_r; deg_wd = degb_r + DW'(1);
        res_status_nxt = gthn_pkg::ST_DONE;
        state_nxt = S_RES;
      end
      // clear the seen map one entry per cycle, then start first level
      S_CLR: begin
        seen_nxt[idx_r[SW-1:0]] = 1'b0;
        if (idx_r == CW'(gthn_pkg::MAX_NODES - 1)) begin
          cur_nxt = sa_r; d_nxt = dega_r; level2_nxt = 1'b0;
          n1_nxt = '0; fi_nxt = '0; any_nxt = 1'b0; pend_nxt = 1'b0;
          state_nxt = S_ADJ;
        end else idx_nxt = idx_r + CW'(1);
      end
      // issue read of entry d-1 of current list
      S_ADJ: begin
        if (d_r == '0) state_nxt = S_NEXTF;
        else state_nxt = S_CHK;
      end
      S_CHK: begin
        d_nxt = d_r - DW'(1);
        if (nb == sa_r || seen_r[nb]) state_nxt = S_ADJ;
        else begin
          seen_nxt[nb] = 1'b1;
          if (!level2_r) begin
            fl_we = 1'b1;
            n1_nxt = n1_r + CW'(1);
          end
          node_ra = nb;
          mem_slot_nxt = nb;
          state_nxt = S_EMIT;
        end
      end
      // node_rd_r holds the id of the new member; emit the held one first
      S_EMIT: begin
        node_ra = mem_slot_r;
        if (!pend_r || !oq_full) begin
          if (pend_r) begin
            push = 1'b1;
            push_data.status = gthn_pkg::ST_DONE;
            push_data.has_member = 1'b1;
            push_data.member_id = pend_id_r;
            push_data.hop = pend_hop2_r ? 2'd2 : 2'd1;
            push_data.last = 1'b0;
          end
          pend_nxt = 1'b1;
          pend_id_nxt = node_rd_r;
          pend_hop2_nxt = level2_r;
          state_nxt = S_ADJ;
        end
      end
      // move to next first-level node; fl_rd_r holds entry fi
      S_NEXTF: begin
        if (fi_r >= n1_r) begin
          state_nxt = S_FLUSH;
        end else begin
          fi_nxt = fi_r + CW'(1);
          cur_nxt = fl_rd_r;
          deg_ra = fl_rd_r;
          level2_nxt = 1'b1;
          state_nxt = S_LDEG;
        end
      end
      // deg_rd_r holds the degree of the new current node
      S_LDEG: begin
        d_nxt = deg_rd_r;
        state_nxt = S_ADJ;
      end
      S_FLUSH: begin
        if (!oq_full) begin
          push = 1'b1;
          push_data.status = gthn_pkg::ST_DONE;
          push_data.has_member = pend_r;
          push_data.member_id = pend_r ? pend_id_r : '0;
          push_data.hop = pend_r ? (pend_hop2_r ? 2'd2 : 2'd1) : 2'd0;
          state_nxt = S_IDLE;
        end
      end
      S_RES: begin
        if (!oq_full) begin
          push = 1'b1;
          push_data.status = res_status_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      node_count_r <= '0;
      seen_r <= '0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      node_count_r <= cnt_nxt;
      seen_r <= seen_nxt;
      pend_r <= pend_nxt;
    end
    idx_r <= idx_nxt; n1_r <= n1_nxt; fi_r <= fi_nxt;
    sa_r <= sa_nxt; sb_r <= sb_nxt; cur_r <= cur_nxt;
    d_r <= d_nxt;
    dega_r <= dega_nxt; degb_r <= degb_nxt;
    which_r <= which_nxt; level2_r <= level2_nxt; any_r <= any_nxt;
    mem_slot_r <= mem_slot_nxt; pend_hop2_r <= pend_hop2_nxt;
    pend_id_r <= pend_id_nxt;
    mode_r <= mode_nxt; ida_r <= ida_nxt; idb_r <= idb_nxt;
    res_status_r <= res_status_nxt;
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= ida_r;
    node_rd_r <= node_mem[node_ra];
  end
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd_r <= adj_mem[adj_ra];
  end
  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd_r <= deg_mem[deg_ra];
  end
  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    fl_rd_r <= fl_mem[fl_ra];
  end

  gthn_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (oq_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_status     = out_data.status;
  assign out_has_member = out_data.has_member;
  assign out_member_id  = out_data.member_id;
  assign out_hop        = out_data.hop;
  assign out_last       = out_data.last;
endmodule
`default_nettype wire

// File: hw/rtl/gthn_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gthn_out_reg: result output register
// One-entry holding register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module gthn_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire gthn_pkg::result_t push_data,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output gthn_pkg::result_t     out_data
);
  logic              vld_r, vld_nxt;
  gthn_pkg::result_t dat_r;

  always_comb begin
    vld_nxt = vld_r;
    if (out_ready) vld_nxt = 1'b0;
    if (push) vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
    if (push) dat_r <= push_data;
  end

  assign full      = vld_r && !out_ready;
  assign out_valid = vld_r;
  assign out_data  = dat_r;
endmodule
`default_nettype wire
